### sv/wgc_pkg.sv
// Shared widths, types and control struct for the Winograd F(2x2,3x3) tile block.
package wgc_pkg;

    localparam int SAMPLE_WIDTH = 16;   // 8..16, low bits of each patch slot
    localparam int WEIGHT_WIDTH = 16;   // 8..16, low bits of each kernel slot

    localparam int SLOT_W    = 16;
    localparam int PATCH_W   = 4 * SLOT_W;
    localparam int KERNEL_W  = 3 * SLOT_W;
    localparam int NUM_TAPS  = 16;

    // Input transform grows two bits, 4x filter transform grows four.
    localparam int V_W    = SAMPLE_WIDTH + 2;
    localparam int U_W    = WEIGHT_WIDTH + 4;
    localparam int PROD_W = V_W + U_W;
    localparam int ACC_W  = 48;
    localparam int OUT_W  = 45;

    typedef logic signed [V_W-1:0]    vval_t;
    typedef logic signed [U_W-1:0]    uval_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [ACC_W-1:0]         acc_t;
    typedef logic signed [OUT_W-1:0]  out_t;

    // Per-stage load enables driven by the top-level handshake logic.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic acc_load;
        logic out_load;
    } wgc_ctl_t;

endpackage

### sv/wgc_front.sv
// Input register, input/filter transforms and the 16 element-wise products.
module wgc_front (
    input  logic                               clk,
    input  wgc_pkg::wgc_ctl_t                  ctl,
    input  logic [3:0][wgc_pkg::PATCH_W-1:0]   patch,
    input  logic [2:0][wgc_pkg::KERNEL_W-1:0]  kernel,
    input  logic                               first_in,
    input  logic                               last_in,
    output wgc_pkg::prod_t                     prod [wgc_pkg::NUM_TAPS],
    output logic                               s2_first,
    output logic                               s2_last
);
    import wgc_pkg::*;

    logic [3:0][PATCH_W-1:0]  s1_patch_reg;
    logic [2:0][KERNEL_W-1:0] s1_kernel_reg;
    logic                     s1_first_reg;
    logic                     s1_last_reg;

    prod_t prod_reg [NUM_TAPS];
    prod_t prod_next [NUM_TAPS];
    logic  s2_first_reg;
    logic  s2_last_reg;

    vval_t d [16];
    vval_t t [16];
    vval_t v [16];
    uval_t w [9];
    uval_t gg [12];
    uval_t u [16];

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            s1_patch_reg  <= patch;
            s1_kernel_reg <= kernel;
            s1_first_reg  <= first_in;
            s1_last_reg   <= last_in;
        end
        if (ctl.s2_load)
        begin
            prod_reg     <= prod_next;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    always_comb
    begin
        // unpack and sign-extend
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                d[i*4+j] = V_W'($signed(s1_patch_reg[i][j*SLOT_W +: SAMPLE_WIDTH]));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w[i*3+j] = U_W'($signed(s1_kernel_reg[i][j*SLOT_W +: WEIGHT_WIDTH]));
            end
        end

        // B^T d B: columns first, then rows
        for (int j = 0; j < 4; j++)
        begin
            t[j]    = d[j] - d[8+j];
            t[4+j]  = d[4+j] + d[8+j];
            t[8+j]  = d[8+j] - d[4+j];
            t[12+j] = d[4+j] - d[12+j];
        end
        for (int i = 0; i < 4; i++)
        begin
            v[i*4+0] = t[i*4+0] - t[i*4+2];
            v[i*4+1] = t[i*4+1] + t[i*4+2];
            v[i*4+2] = t[i*4+2] - t[i*4+1];
            v[i*4+3] = t[i*4+1] - t[i*4+3];
        end

        // (2G) g (2G)^T, exact integers
        for (int j = 0; j < 3; j++)
        begin
            gg[0*3+j] = w[j] <<< 1;
            gg[1*3+j] = w[j] + w[3+j] + w[6+j];
            gg[2*3+j] = w[j] - w[3+j] + w[6+j];
            gg[3*3+j] = w[6+j] <<< 1;
        end
        for (int i = 0; i < 4; i++)
        begin
            u[i*4+0] = gg[i*3+0] <<< 1;
            u[i*4+1] = gg[i*3+0] + gg[i*3+1] + gg[i*3+2];
            u[i*4+2] = gg[i*3+0] - gg[i*3+1] + gg[i*3+2];
            u[i*4+3] = gg[i*3+2] <<< 1;
        end

        for (int k = 0; k < NUM_TAPS; k++)
        begin
            prod_next[k] = u[k] * v[k];
        end
    end

    assign prod     = prod_reg;
    assign s2_first = s2_first_reg;
    assign s2_last  = s2_last_reg;

endmodule

### sv/wgc_acc.sv
// Sixteen transform-domain accumulators, cleared by the first-channel flag.
module wgc_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  wgc_pkg::wgc_ctl_t ctl,
    input  wgc_pkg::prod_t    prod [wgc_pkg::NUM_TAPS],
    input  logic              first_in,
    output wgc_pkg::acc_t     acc [wgc_pkg::NUM_TAPS]
);
    import wgc_pkg::*;

    acc_t acc_reg  [NUM_TAPS];
    acc_t acc_next [NUM_TAPS];

    always_comb
    begin
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            acc_next[k] = (first_in ? '0 : acc_reg[k]) + ACC_W'(prod[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else if (ctl.acc_load)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### sv/wgc_otx.sv
// Output transform A^T M A, exact divide by four, and the result register.
module wgc_otx (
    input  logic              clk,
    input  wgc_pkg::wgc_ctl_t ctl,
    input  wgc_pkg::acc_t     acc [wgc_pkg::NUM_TAPS],
    output wgc_pkg::out_t     out_top_left,
    output wgc_pkg::out_t     out_top_right,
    output wgc_pkg::out_t     out_bottom_left,
    output wgc_pkg::out_t     out_bottom_right
);
    import wgc_pkg::*;

    // Modulo-2^48 arithmetic is enough: only bits 2..46 are kept.
    acc_t p [8];
    acc_t y [4];
    out_t tile_reg  [4];
    out_t tile_next [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            p[j]   = acc[j] + acc[4+j] + acc[8+j];
            p[4+j] = acc[4+j] - acc[8+j] - acc[12+j];
        end
        for (int i = 0; i < 2; i++)
        begin
            y[i*2+0] = p[i*4+0] + p[i*4+1] + p[i*4+2];
            y[i*2+1] = p[i*4+1] - p[i*4+2] - p[i*4+3];
        end
        for (int k = 0; k < 4; k++)
        begin
            tile_next[k] = y[k][OUT_W+1:2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            tile_reg <= tile_next;
        end
    end

    assign out_top_left     = tile_reg[0];
    assign out_top_right    = tile_reg[1];
    assign out_bottom_left  = tile_reg[2];
    assign out_bottom_right = tile_reg[3];

endmodule

### sv/winograd_conv3x3_tile_top.sv
// Top level of the Winograd F(2x2,3x3) per-channel tile convolution block.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_stall    | patch_row0..3, kernel_row0..2, flags
//  out     | output    | out_valid / out_stall  | out_top_left .. out_bottom_right
//
// One transaction per cycle sustained while out_stall is low. Four register stages: input register,
// product register (transforms plus 16 parallel multiplies), accumulator update,
// output register (output transform). A last-channel transaction shows its
// tile after the product, accumulator and output registers. Reset clears all valid bits and
// zeroes the accumulators. A stalled output backs up stage by stage; in_stall rises only
// when every stage is full, and the accumulators hold while a tile waits.
module winograd_conv3x3_tile_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wgc_pkg::PATCH_W-1:0]   patch_row0,
    input  logic [wgc_pkg::PATCH_W-1:0]   patch_row1,
    input  logic [wgc_pkg::PATCH_W-1:0]   patch_row2,
    input  logic [wgc_pkg::PATCH_W-1:0]   patch_row3,
    input  logic [wgc_pkg::KERNEL_W-1:0]  kernel_row0,
    input  logic [wgc_pkg::KERNEL_W-1:0]  kernel_row1,
    input  logic [wgc_pkg::KERNEL_W-1:0]  kernel_row2,
    input  logic                          first_channel,
    input  logic                          last_channel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wgc_pkg::out_t                 out_top_left,
    output wgc_pkg::out_t                 out_top_right,
    output wgc_pkg::out_t                 out_bottom_left,
    output wgc_pkg::out_t                 out_bottom_right
);
    import wgc_pkg::*;

    wgc_ctl_t ctl;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic e3_valid_reg, e3_valid_next;   // accumulators hold a tile to emit
    logic out_valid_reg, out_valid_next;

    logic ready1, ready2, ready3, ready4;

    logic [3:0][PATCH_W-1:0]  patch;
    logic [2:0][KERNEL_W-1:0] kernel;

    prod_t prod [NUM_TAPS];
    acc_t  acc  [NUM_TAPS];
    logic  s2_first;
    logic  s2_last;

    assign patch  = {patch_row3, patch_row2, patch_row1, patch_row0};
    assign kernel = {kernel_row2, kernel_row1, kernel_row0};

    // Ready chain: a stage may load when empty or when it drains the same cycle.
    // The accumulator stage also waits while a pending tile has not moved out.
    assign ready4 = !out_valid_reg || !out_stall;
    assign ready3 = !e3_valid_reg || ready4;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;

    assign ctl.s1_load  = in_valid && ready1;
    assign ctl.s2_load  = s1_valid_reg && ready2;
    assign ctl.acc_load = s2_valid_reg && ready3;
    assign ctl.out_load = e3_valid_reg && ready4;

    assign s1_valid_next  = ctl.s1_load || (s1_valid_reg && !ctl.s2_load);
    assign s2_valid_next  = ctl.s2_load || (s2_valid_reg && !ctl.acc_load);
    assign e3_valid_next  = (ctl.acc_load && s2_last) || (e3_valid_reg && !ctl.out_load);
    assign out_valid_next = ctl.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            e3_valid_reg  <= e3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = !ready1;
    assign out_valid = out_valid_reg;

    wgc_front u_front (
        .clk      (clk),
        .ctl      (ctl),
        .patch    (patch),
        .kernel   (kernel),
        .first_in (first_channel),
        .last_in  (last_channel),
        .prod     (prod),
        .s2_first (s2_first),
        .s2_last  (s2_last)
    );

    wgc_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .prod     (prod),
        .first_in (s2_first),
        .acc      (acc)
    );

    wgc_otx u_otx (
        .clk              (clk),
        .ctl              (ctl),
        .acc              (acc),
        .out_top_left     (out_top_left),
        .out_top_right    (out_top_right),
        .out_bottom_left  (out_bottom_left),
        .out_bottom_right (out_bottom_right)
    );

    // With the output free, nothing may back-pressure the input.
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output side is free");

    // A waiting tile must not be overwritten in the accumulators.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        e3_valid_reg && out_valid_reg && out_stall |-> !ctl.acc_load)
        else $error("accumulators updated while a tile is pending");

    // A last-channel update always leaves a tile pending.
    a_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.acc_load && s2_last |=> e3_valid_reg)
        else $error("last channel did not mark a pending tile");

    // A new output only ever follows a pending tile.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> e3_valid_reg && ready4)
        else $error("output loaded without a pending tile");

endmodule
